// ----- sv/ifr_pkg.sv -----
package ifr_pkg;

  localparam int SLOTS_DEF = 16;
  localparam logic [15:0] TIMEOUT_RST = 16'd30;

  localparam logic [1:0] ST_WAIT     = 2'd0;
  localparam logic [1:0] ST_UNFRAG   = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [16:0] RECV_MAX   = 17'h1FFFF;
  localparam logic [17:0] TOTAL_NONE = 18'h3FFFF;

  typedef struct packed {
    logic [15:0] ident;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } ifr_key_t;

  typedef struct packed {
    ifr_key_t    key;
    logic [16:0] received;
    logic [17:0] total;
    logic [31:0] stamp;
  } ifr_rec_t;

  typedef struct packed {
    logic        stale;
    logic        match;
    logic        complete;
    logic [17:0] total;
  } ifr_eval_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_UPD,
    S_OUT
  } ifr_state_t;

endpackage

// ----- sv/ifr_slot_mem.sv -----
module ifr_slot_mem
  import ifr_pkg::*;
#(
  parameter int DEPTH = SLOTS_DEF,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output ifr_rec_t      rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  ifr_rec_t      wr_data
);

  ifr_rec_t mem [DEPTH];
  ifr_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/ifr_slot_unit.sv -----
module ifr_slot_unit
  import ifr_pkg::*;
(
  input  ifr_rec_t    rec,
  input  logic        rekey,
  input  ifr_key_t    key,
  input  logic [31:0] now,
  input  logic [15:0] timeout,
  input  logic [15:0] offset,
  input  logic [15:0] plen,
  input  logic        mf,
  output ifr_eval_t   eval,
  output ifr_rec_t    new_rec
);

  ifr_rec_t    base;
  logic [31:0] age;
  logic [17:0] recv_sum;

  always_comb begin
    age        = now - rec.stamp;
    eval.stale = age > {16'd0, timeout};
    eval.match = rec.key == key;

    if (rekey) begin
      base.key      = key;
      base.received = '0;
      base.total    = TOTAL_NONE;
      base.stamp    = now;
    end else begin
      base = rec;
    end

    new_rec  = base;
    recv_sum = {1'b0, base.received} + {2'd0, plen};
    new_rec.received = recv_sum[17] ? RECV_MAX : recv_sum[16:0];
    if (!mf) begin
      new_rec.total = {2'd0, offset} + {2'd0, plen};
    end

    eval.total    = new_rec.total;
    eval.complete = (new_rec.total != '0) && !new_rec.total[17] &&
                    ({1'b0, new_rec.received} >= new_rec.total);
  end

endmodule

// ----- sv/ip_fragment_reassembly_tracker.sv -----
// Steps: an unfragmented packet goes from S_IDLE straight to S_OUT; a fragment
// walks the used slots (S_RD, S_CMP per slot), then S_UPD unless full, then S_OUT.
// One word at a time: the next word is taken the cycle after the result
// loads, and loading waits while a result not yet taken by out_ready holds
// the result register. The walk reads each slot record in S_RD, checks it in S_CMP.
// Reset (rst_n low, synchronous): no slots in use, timeout 30 s, outputs idle.
module ip_fragment_reassembly_tracker
  import ifr_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_ident,
  input  logic [7:0]  in_proto,
  input  logic [31:0] in_source_addr,
  input  logic [31:0] in_dest_addr,
  input  logic [15:0] in_flags_and_offset,
  input  logic [3:0]  in_header_words,
  input  logic [15:0] in_total_length,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_index,
  output logic [15:0] out_write_offset,
  output logic [15:0] out_payload_length,
  output logic [16:0] out_delivered_length
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  ifr_state_t state_r, state_nxt;

  logic [15:0]      timeout_r;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             rekey_r, rekey_nxt;
  ifr_key_t         key_r;
  logic [31:0]      now_r;
  logic [15:0]      offset_r;
  logic [15:0]      plen_r;
  logic             mf_r;
  logic [1:0]       status_r, status_nxt;
  logic [16:0]      deliv_r, deliv_nxt;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [3:0]       out_slot_r;
  logic [15:0]      out_offset_r;
  logic [15:0]      out_plen_r;
  logic [16:0]      out_deliv_r;

  logic        accept;
  logic [15:0] in_offset;
  logic        in_mf;
  logic [5:0]  in_hlen;
  logic [15:0] in_plen;
  logic        in_unfrag;

  logic      mem_rd_en;
  logic      mem_wr_en;
  logic      out_load;
  ifr_rec_t  rd_rec;
  ifr_rec_t  new_rec;
  ifr_rec_t  wr_rec;
  ifr_eval_t eval;
  logic      last_slot;
  logic      table_full;

  assign accept    = in_valid && in_ready;
  assign in_offset = {in_flags_and_offset[12:0], 3'b000};
  assign in_mf     = in_flags_and_offset[13];
  assign in_hlen   = {in_header_words, 2'b00};
  assign in_plen   = (in_total_length > {10'd0, in_hlen}) ?
                     (in_total_length - {10'd0, in_hlen}) : 16'd0;
  assign in_unfrag = !in_mf && (in_offset == 16'd0);

  assign last_slot  = (CNT_W'(idx_r) + CNT_W'(1)) == used_r;
  assign table_full = used_r == CNT_W'(SLOTS);

  ifr_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_rec),
    .wr_en   (mem_wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_rec)
  );

  ifr_slot_unit u_unit (
    .rec     (rd_rec),
    .rekey   (rekey_r),
    .key     (key_r),
    .now     (now_r),
    .timeout (timeout_r),
    .offset  (offset_r),
    .plen    (plen_r),
    .mf      (mf_r),
    .eval    (eval),
    .new_rec (new_rec)
  );

  assign wr_rec = eval.complete ? '0 : new_rec;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_unfrag) begin
            state_nxt = S_OUT;
          end else if (used_r == '0) begin
            state_nxt = S_UPD;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD:  state_nxt = S_CMP;
      S_CMP: begin
        if (eval.stale || eval.match) begin
          state_nxt = S_UPD;
        end else if (last_slot) begin
          state_nxt = table_full ? S_OUT : S_UPD;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_UPD: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_rd_en = 1'b0;
    mem_wr_en = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready  = 1'b1;
      S_RD:   mem_rd_en = 1'b1;
      S_CMP:  ;
      S_UPD:  mem_wr_en = 1'b1;
      S_OUT:  out_load  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // walk datapath
  always_comb begin
    used_nxt   = used_r;
    idx_nxt    = idx_r;
    rekey_nxt  = rekey_r;
    status_nxt = status_r;
    deliv_nxt  = deliv_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt    = '0;
          rekey_nxt  = 1'b0;
          status_nxt = in_unfrag ? ST_UNFRAG : ST_WAIT;
          deliv_nxt  = in_unfrag ? {1'b0, in_plen} : 17'd0;
          if (!in_unfrag && used_r == '0) begin
            rekey_nxt = 1'b1;
            used_nxt  = used_r + CNT_W'(1);
          end
        end
      end
      S_CMP: begin
        if (eval.stale) begin
          rekey_nxt = 1'b1;
        end else if (eval.match) begin
          rekey_nxt = 1'b0;
        end else if (last_slot) begin
          if (table_full) begin
            status_nxt = ST_FULL;
            idx_nxt    = '0;
          end else begin
            rekey_nxt = 1'b1;
            idx_nxt   = IDX_W'(used_r);
            used_nxt  = used_r + CNT_W'(1);
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_UPD: begin
        if (eval.complete) begin
          status_nxt = ST_COMPLETE;
          deliv_nxt  = eval.total[16:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= TIMEOUT_RST;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    rekey_r  <= rekey_nxt;
    status_r <= status_nxt;
    deliv_r  <= deliv_nxt;
    if (accept) begin
      key_r    <= '{ident: in_ident, proto: in_proto,
                    src: in_source_addr, dst: in_dest_addr};
      now_r    <= in_now_seconds;
      offset_r <= in_offset;
      plen_r   <= in_plen;
      mf_r     <= in_mf;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_slot_r   <= (status_r == ST_UNFRAG) ? 4'd0 : 4'(idx_r);
      out_offset_r <= offset_r;
      out_plen_r   <= plen_r;
      out_deliv_r  <= deliv_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_slot_index       = out_slot_r;
  assign out_write_offset     = out_offset_r;
  assign out_payload_length   = out_plen_r;
  assign out_delivered_length = out_deliv_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(SLOTS))
    else $error("slot count beyond table size");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && status_r == ST_FULL |-> table_full)
    else $error("table full reported with free slots");

  a_unfrag_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNFRAG |->
      out_delivered_length == {1'b0, out_payload_length})
    else $error("unfragmented length mismatch");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("ready while a word is in flight");

endmodule

// ----- verif/ip_fragment_reassembly_tracker_test.sv -----
module ip_fragment_reassembly_tracker_test;
  import ifr_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int POOL = 24;
  localparam int PHASE_WORDS = 240;

  localparam ifr_key_t KEY_A = {16'h1234, 8'd17, 32'h0A000001, 32'h0A000002};
  localparam ifr_key_t KEY_D = {16'h8001, 8'd6, 32'hAC100001, 32'hAC100002};
  localparam ifr_key_t KEY_E = {16'h00FF, 8'd1, 32'h7F000001, 32'hFFFFFFFE};
  localparam ifr_key_t KEY_ONES = '1;
  localparam ifr_key_t KEY_ZERO = '0;

  typedef struct packed {
    ifr_key_t    key;
    logic [15:0] fo;
    logic [3:0]  hw;
    logic [15:0] tl;
    logic [31:0] now;
  } frag_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] offset;
    logic [15:0] plen;
    logic [16:0] deliv;
  } report_t;

  typedef struct packed {
    frag_t   f;
    logic    typed;
    report_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  frag_t       in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_slot_index;
  logic [15:0] out_write_offset;
  logic [15:0] out_payload_length;
  logic [16:0] out_delivered_length;

  ip_fragment_reassembly_tracker u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_ident            (in_word.key.ident),
    .in_proto            (in_word.key.proto),
    .in_source_addr      (in_word.key.src),
    .in_dest_addr        (in_word.key.dst),
    .in_flags_and_offset (in_word.fo),
    .in_header_words     (in_word.hw),
    .in_total_length     (in_word.tl),
    .in_now_seconds      (in_word.now),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_write_offset    (out_write_offset),
    .out_payload_length  (out_payload_length),
    .out_delivered_length(out_delivered_length)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // reassembly table as the block should hold it
  ifr_key_t    trk_key   [NSLOT];
  logic [16:0] trk_rcv   [NSLOT];
  logic [17:0] trk_tot   [NSLOT];
  logic [31:0] trk_stamp [NSLOT];
  int unsigned trk_used = 0;
  logic [15:0] age_limit = TIMEOUT_RST;

  report_t report_q[$];
  int fails = 0;

  function automatic void open_slot(int unsigned i, frag_t f);
    trk_key[i]   = f.key;
    trk_rcv[i]   = '0;
    trk_tot[i]   = TOTAL_NONE;
    trk_stamp[i] = f.now;
  endfunction

  function automatic report_t track_fragment(frag_t f);
    report_t     r;
    int unsigned hdr, offs, plen, sum, idx;
    logic [31:0] age;
    logic [17:0] tot;
    logic        mf, hit;
    hdr  = 4 * int'(f.hw);
    offs = 8 * int'(f.fo[12:0]);
    mf   = f.fo[13];
    plen = (int'(f.tl) > hdr) ? int'(f.tl) - hdr : 0;
    r = '0;
    r.status = ST_WAIT;
    r.offset = offs[15:0];
    r.plen = plen[15:0];
    if (!mf && offs == 0) begin
      r.status = ST_UNFRAG;
      r.deliv = plen[16:0];
    end else begin
      hit = 1'b0;
      for (idx = 0; idx < trk_used; idx++) begin
        age = f.now - trk_stamp[idx];
        if (age > 32'(age_limit)) begin
          open_slot(idx, f);
          hit = 1'b1;
          break;
        end
        if (trk_key[idx] == f.key) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit && trk_used < NSLOT) begin
        idx = trk_used;
        trk_used++;
        open_slot(idx, f);
        hit = 1'b1;
      end
      if (!hit) begin
        r.status = ST_FULL;
      end else begin
        sum = int'(trk_rcv[idx]) + plen;
        trk_rcv[idx] = (sum > int'(RECV_MAX)) ? RECV_MAX : sum[16:0];
        if (!mf) begin
          trk_tot[idx] = 18'(offs + plen);
        end
        tot = trk_tot[idx];
        r.slot = idx[3:0];
        if (tot != 0 && !tot[17] && 18'(trk_rcv[idx]) >= tot) begin
          r.status = ST_COMPLETE;
          r.deliv = tot[16:0];
          trk_key[idx]   = '0;
          trk_rcv[idx]   = '0;
          trk_tot[idx]   = '0;
          trk_stamp[idx] = '0;
        end
      end
    end
    return r;
  endfunction

  task automatic cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : check_results
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        want = report_q.pop_front();
        cmp_field("status", want.status, out_status);
        cmp_field("slot_index", want.slot, out_slot_index);
        cmp_field("write_offset", want.offset, out_write_offset);
        cmp_field("payload_length", want.plen, out_payload_length);
        cmp_field("delivered_length", want.deliv, out_delivered_length);
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  int burst_left = 0;

  task automatic send_word(input frag_t f, input logic typed, input report_t want);
    report_t got;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_word <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    got = track_fragment(f);
    report_q.push_back(typed ? want : got);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] v);
    drain();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    age_limit = v;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic frag_t mk(ifr_key_t k, logic [15:0] fo, logic [3:0] hw,
                               logic [15:0] tl, logic [31:0] now);
    frag_t f;
    f.key = k;
    f.fo = fo;
    f.hw = hw;
    f.tl = tl;
    f.now = now;
    return f;
  endfunction

  function automatic report_t rs(logic [1:0] s, logic [3:0] slot, logic [15:0] off,
                                 logic [15:0] pl, logic [16:0] dl);
    report_t r;
    r.status = s;
    r.slot = slot;
    r.offset = off;
    r.plen = pl;
    r.deliv = dl;
    return r;
  endfunction

  row_t dir_q[$];

  function automatic void add_row(frag_t f, logic typed, report_t want);
    dir_q.push_back({f, typed, want});
  endfunction

  initial begin : stim
    ifr_key_t    pool [POOL];
    logic [15:0] limits [6];
    frag_t       gen_q[$];
    frag_t       f;
    logic [31:0] wall;
    int          k, j, p, pick, nf, units, base, plen, sum, lo, r2;
    logic        big;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // timeout still at its reset value here
    add_row(mk(KEY_A, 16'h0000, 4'd5, 16'd100, 32'd1000), 1'b1,
            rs(ST_UNFRAG, 4'd0, 16'd0, 16'd80, 17'd80));
    add_row(mk(KEY_A, 16'h4000, 4'd15, 16'd0, 32'd1000), 1'b1,
            rs(ST_UNFRAG, 4'd0, 16'd0, 16'd0, 17'd0));
    add_row(mk(KEY_ONES, 16'h8000, 4'd0, 16'hFFFF, 32'd1000), 1'b1,
            rs(ST_UNFRAG, 4'd0, 16'd0, 16'd65535, 17'd65535));
    add_row(mk(KEY_A, 16'h2000, 4'd5, 16'd28, 32'd1000), 1'b1,
            rs(ST_WAIT, 4'd0, 16'd0, 16'd8, 17'd0));
    add_row(mk(KEY_A, 16'h0001, 4'd5, 16'd28, 32'd1000), 1'b1,
            rs(ST_COMPLETE, 4'd0, 16'd8, 16'd8, 17'd16));
    // widest offset and payload; third word saturates the received count
    add_row(mk(KEY_ONES, 16'h3FFF, 4'd0, 16'hFFFF, 32'd1000), 1'b1,
            rs(ST_WAIT, 4'd0, 16'd65528, 16'd65535, 17'd0));
    add_row(mk(KEY_ONES, 16'h2000, 4'd0, 16'hFFFF, 32'd1000), 1'b1,
            rs(ST_WAIT, 4'd0, 16'd0, 16'd65535, 17'd0));
    add_row(mk(KEY_ONES, 16'h1FFF, 4'd0, 16'hFFFF, 32'd1000), 1'b1,
            rs(ST_COMPLETE, 4'd0, 16'd65528, 16'd65535, 17'd131063));
    // all-zero keys hit the cleared slot while it is still fresh
    add_row(mk(KEY_ZERO, 16'h2000, 4'd5, 16'd40, 32'd20), 1'b1,
            rs(ST_WAIT, 4'd0, 16'd0, 16'd20, 17'd0));
    // header longer than the packet
    add_row(mk(KEY_E, 16'h2003, 4'd15, 16'd10, 32'd1000), 1'b1,
            rs(ST_WAIT, 4'd0, 16'd24, 16'd0, 17'd0));
    // age taken across the wrap of the seconds counter
    add_row(mk(KEY_D, 16'h2000, 4'd5, 16'd28, 32'hFFFFFFF0), 1'b1,
            rs(ST_WAIT, 4'd0, 16'd0, 16'd8, 17'd0));
    add_row(mk(KEY_D, 16'h0001, 4'd5, 16'd28, 32'd5), 1'b1,
            rs(ST_COMPLETE, 4'd0, 16'd8, 16'd8, 17'd16));
    // fill every slot, then one more
    for (k = 1; k <= 16; k++) begin
      add_row(mk({16'(16'h5000 + k), 8'd6, 32'(32'hC0A80000 + k), 32'hC0A80101},
                 16'(16'h2000 + k), 4'd5, 16'd100, 32'd5),
              k == 16, rs(ST_FULL, 4'd0, 16'd128, 16'd80, 17'd0));
    end
    foreach (dir_q[k]) send_word(dir_q[k].f, dir_q[k].typed, dir_q[k].want);

    pool[0] = '0;
    pool[1] = '1;
    for (k = 2; k < POOL; k++) begin
      if (k % 4 == 3) begin
        pool[k] = pool[k - 1];
        case ((k / 4) % 4)
          0: pool[k].ident[0] = ~pool[k].ident[0];
          1: pool[k].proto[7] = ~pool[k].proto[7];
          2: pool[k].src[31] = ~pool[k].src[31];
          default: pool[k].dst[0] = ~pool[k].dst[0];
        endcase
      end else begin
        pool[k].ident = 16'($urandom);
        pool[k].proto = 8'($urandom);
        pool[k].src = $urandom;
        pool[k].dst = $urandom;
      end
    end

    limits[0] = 16'hFFFF;
    limits[1] = 16'd0;
    limits[2] = 16'd30;
    limits[3] = 16'd7;
    limits[4] = 16'($urandom_range(1, 65534));
    limits[5] = 16'd300;
    wall = 32'd100000;

    for (p = 0; p < 6; p++) begin
      set_timeout(limits[p]);
      gen_q.delete();
      while (gen_q.size() < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          f.key.ident = 16'($urandom);
          f.key.proto = 8'($urandom);
          f.key.src = $urandom;
          f.key.dst = $urandom;
          f.fo = 16'($urandom);
          f.hw = 4'($urandom);
          f.tl = 16'($urandom);
          gen_q.push_back(f);
        end else if (pick < 16) begin
          f.key = pool[$urandom_range(0, POOL - 1)];
          f.fo = {2'($urandom), 14'd0};
          f.hw = 4'($urandom);
          f.tl = 16'($urandom_range(0, 1500));
          gen_q.push_back(f);
        end else begin
          // one datagram cut into fragments, some lost or repeated
          f.key = pool[$urandom_range(0, POOL - 1)];
          nf = $urandom_range(2, 4);
          big = ($urandom_range(0, 49) == 0);
          base = 0;
          for (j = 0; j < nf; j++) begin
            units = big ? $urandom_range(2000, 8100) : $urandom_range(1, 8);
            if (j == nf - 1) begin
              plen = big ? $urandom_range(0, 65535) : $urandom_range(0, 64);
            end else begin
              plen = units * 8;
            end
            if (big) begin
              f.hw = 4'd0;
            end else begin
              f.hw = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd5;
            end
            sum = 4 * int'(f.hw) + plen;
            f.tl = (sum > 65535) ? 16'hFFFF : 16'(sum);
            f.fo = {($urandom_range(0, 9) == 0), 1'($urandom), (j != nf - 1), 13'(base)};
            base += units;
            r2 = $urandom_range(0, 99);
            lo = (gen_q.size() > 6) ? gen_q.size() - 6 : 0;
            if (r2 >= 8) gen_q.insert($urandom_range(lo, gen_q.size()), f);
            if (r2 >= 95) gen_q.insert($urandom_range(lo, gen_q.size()), f);
          end
        end
      end

      for (k = 0; k < gen_q.size(); k++) begin
        if (p == 1 && k == 60) hold_ask++;
        if (p == 2 && k == 120) drain();
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          wall = $urandom;
        end else if (pick < 5) begin
          wall += $urandom_range(20, 2000);
        end else begin
          wall += $urandom_range(0, 2);
        end
        f = gen_q[k];
        f.now = wall;
        send_word(f, 1'b0, '0);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ifr_pkg.sv
sv/ifr_slot_mem.sv
sv/ifr_slot_unit.sv
sv/ip_fragment_reassembly_tracker.sv
verif/ip_fragment_reassembly_tracker_test.sv
